@@ hw/rtl/gdad_pkg.sv @@
package gdad_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned AddW   = 16;
  // running day count: one legal day plus the largest add
  localparam int unsigned DSumW  = 17;
  localparam int unsigned CentW  = 8;
  localparam int unsigned Rem100W = 7;

  localparam logic [YearW-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;
  localparam logic [DayW-1:0]   DAY_LAST  = 5'd31;
  localparam logic [DayW-1:0]   DAY_FIRST = 5'd1;

  // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y
  localparam logic [12:0]   DIV100_RECIP = 13'd5243;
  localparam int unsigned   DIV100_SHIFT = 19;
  localparam logic [Rem100W-1:0] REM100_LAST = 7'd99;
  localparam logic [6:0]    HUNDRED      = 7'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_ROLL,
    ST_HOLD
  } state_t;

  function automatic logic is_leap(input logic [1:0] y_mod4,
                                   input logic [Rem100W-1:0] y_mod100,
                                   input logic [1:0] cent_mod4);
    is_leap = ((y_mod4 == 2'd0) && (y_mod100 != '0)) ||
              ((y_mod100 == '0) && (cent_mod4 == 2'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
      4'd2:    month_len = leap ? 5'd29 : 5'd28;
      default: month_len = 5'd0;
    endcase
  endfunction

endpackage

@@ hw/rtl/gregorian_date_add_days.sv @@
// Gregorian date plus day count.
// Input channel (in_valid / in_stall): one beat carries a start date
// (year, month, day) and a day count to add. in_stall is high from the
// accepting edge until the result has been moved into the output register.
// Output channel (out_valid / out_stall): one beat per input beat with the
// end date, date_valid (start date was legal) and year_overflow (result
// passed year 9999 and saturated to 9999-12-31). An illegal start date
// returns 0-01-01 with both flags low.
// Steps: accept, century divide, start-date check, one roll step per month
// rolled over (none for an illegal start date), then a hold until the
// output register frees. The month roll is a single month-length compare
// and subtract reused once per cycle; the leap test comes from year
// residues mod 4, 100 and 400 stepped along with the year.
// Throughput: one item at a time; a new beat is taken while the previous
// result still waits in the output register.
// Reset (synchronous, rst_n low) returns to idle and drops out_valid.
// While out_stall is high the result holds; a finished item waits until the
// output register frees.
module gregorian_date_add_days (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gdad_pkg::YearW-1:0]   in_start_year,
  input  logic [gdad_pkg::MonthW-1:0]  in_start_month,
  input  logic [gdad_pkg::DayW-1:0]    in_start_day,
  input  logic [gdad_pkg::AddW-1:0]    in_add_days,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gdad_pkg::YearW-1:0]   out_end_year,
  output logic [gdad_pkg::MonthW-1:0]  out_end_month,
  output logic [gdad_pkg::DayW-1:0]    out_end_day,
  output logic                         out_date_valid,
  output logic                         out_year_overflow
);

  gdad_pkg::state_t state_r, state_nxt;

  logic [gdad_pkg::YearW-1:0]   y_r, y_nxt;
  logic [gdad_pkg::MonthW-1:0]  m_r, m_nxt;
  logic [gdad_pkg::DSumW-1:0]   d_r, d_nxt;
  logic [gdad_pkg::AddW-1:0]    n_r, n_nxt;
  logic [gdad_pkg::CentW-1:0]   cent_r, cent_nxt;
  logic [gdad_pkg::Rem100W-1:0] rem_r, rem_nxt;
  logic [1:0]                   cmod_r, cmod_nxt;
  logic                         ok_r, ok_nxt;
  logic                         ovf_r, ovf_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [gdad_pkg::YearW-1:0]   oy_r, oy_nxt;
  logic [gdad_pkg::MonthW-1:0]  om_r, om_nxt;
  logic [gdad_pkg::DayW-1:0]    od_r, od_nxt;
  logic                         ook_r, ook_nxt;
  logic                         oovf_r, oovf_nxt;

  logic                         in_acc;
  logic                         slot_free;
  logic [26:0]                  prod;
  logic [gdad_pkg::YearW-1:0]   cent_x100;
  logic [gdad_pkg::YearW-1:0]   rem_full;
  logic                         leap_chk, leap_roll;
  logic [gdad_pkg::DayW-1:0]    len_chk, len_roll;
  logic                         start_ok;
  logic                         roll_more;

  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // reciprocal multiply for the century number
  assign prod = {13'd0, y_r} * {14'd0, gdad_pkg::DIV100_RECIP};

  assign cent_x100 = gdad_pkg::YearW'(cent_r) * gdad_pkg::YearW'(gdad_pkg::HUNDRED);
  assign rem_full  = y_r - cent_x100;
  assign leap_chk  = gdad_pkg::is_leap(y_r[1:0], rem_full[gdad_pkg::Rem100W-1:0],
                                       cent_r[1:0]);
  assign len_chk   = gdad_pkg::month_len(m_r, leap_chk);
  assign start_ok  = (y_r <= gdad_pkg::YEAR_MAX) && (len_chk != '0) &&
                     (d_r[gdad_pkg::DayW-1:0] != '0) &&
                     (d_r[gdad_pkg::DayW-1:0] <= len_chk);

  assign leap_roll = gdad_pkg::is_leap(y_r[1:0], rem_r, cmod_r);
  assign len_roll  = gdad_pkg::month_len(m_r, leap_roll);
  assign roll_more = d_r > {{(gdad_pkg::DSumW-gdad_pkg::DayW){1'b0}}, len_roll};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdad_pkg::ST_IDLE:  if (in_acc) state_nxt = gdad_pkg::ST_DIV;
      gdad_pkg::ST_DIV:   state_nxt = gdad_pkg::ST_CHECK;
      gdad_pkg::ST_CHECK: state_nxt = start_ok ? gdad_pkg::ST_ROLL : gdad_pkg::ST_HOLD;
      gdad_pkg::ST_ROLL: begin
        if (!roll_more) begin
          state_nxt = gdad_pkg::ST_HOLD;
        end else if (m_r == gdad_pkg::MONTH_DEC && y_r == gdad_pkg::YEAR_MAX) begin
          state_nxt = gdad_pkg::ST_HOLD;
        end
      end
      gdad_pkg::ST_HOLD:  if (slot_free) state_nxt = gdad_pkg::ST_IDLE;
      default:            state_nxt = gdad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    y_nxt    = y_r;
    m_nxt    = m_r;
    d_nxt    = d_r;
    n_nxt    = n_r;
    cent_nxt = cent_r;
    rem_nxt  = rem_r;
    cmod_nxt = cmod_r;
    ok_nxt   = ok_r;
    ovf_nxt  = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    oy_nxt   = oy_r;
    om_nxt   = om_r;
    od_nxt   = od_r;
    ook_nxt  = ook_r;
    oovf_nxt = oovf_r;
    case (state_r)
      gdad_pkg::ST_IDLE: begin
        if (in_acc) begin
          y_nxt   = in_start_year;
          m_nxt   = in_start_month;
          d_nxt   = {{(gdad_pkg::DSumW-gdad_pkg::DayW){1'b0}}, in_start_day};
          n_nxt   = in_add_days;
          ovf_nxt = 1'b0;
        end
      end
      gdad_pkg::ST_DIV: begin
        cent_nxt = prod[gdad_pkg::DIV100_SHIFT +: gdad_pkg::CentW];
      end
      gdad_pkg::ST_CHECK: begin
        ok_nxt   = start_ok;
        rem_nxt  = rem_full[gdad_pkg::Rem100W-1:0];
        cmod_nxt = cent_r[1:0];
        if (start_ok) begin
          d_nxt = d_r + {1'b0, n_r};
        end else begin
          // illegal start: fixed 0-01-01 result
          y_nxt = '0;
          m_nxt = gdad_pkg::MONTH_JAN;
          d_nxt = {{(gdad_pkg::DSumW-gdad_pkg::DayW){1'b0}}, gdad_pkg::DAY_FIRST};
        end
      end
      gdad_pkg::ST_ROLL: begin
        if (roll_more) begin
          d_nxt = d_r - {{(gdad_pkg::DSumW-gdad_pkg::DayW){1'b0}}, len_roll};
          if (m_r == gdad_pkg::MONTH_DEC) begin
            if (y_r == gdad_pkg::YEAR_MAX) begin
              // saturate at the top of the year range
              m_nxt   = gdad_pkg::MONTH_DEC;
              d_nxt   = {{(gdad_pkg::DSumW-gdad_pkg::DayW){1'b0}}, gdad_pkg::DAY_LAST};
              ovf_nxt = 1'b1;
            end else begin
              m_nxt = gdad_pkg::MONTH_JAN;
              y_nxt = y_r + 1'b1;
              if (rem_r == gdad_pkg::REM100_LAST) begin
                rem_nxt  = '0;
                cmod_nxt = cmod_r + 1'b1;
              end else begin
                rem_nxt = rem_r + 1'b1;
              end
            end
          end else begin
            m_nxt = m_r + 1'b1;
          end
        end
      end
      gdad_pkg::ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          oy_nxt   = y_r;
          om_nxt   = m_r;
          od_nxt   = d_r[gdad_pkg::DayW-1:0];
          ook_nxt  = ok_r;
          oovf_nxt = ovf_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdad_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r    <= y_nxt;
    m_r    <= m_nxt;
    d_r    <= d_nxt;
    n_r    <= n_nxt;
    cent_r <= cent_nxt;
    rem_r  <= rem_nxt;
    cmod_r <= cmod_nxt;
    ok_r   <= ok_nxt;
    ovf_r  <= ovf_nxt;
    oy_r   <= oy_nxt;
    om_r   <= om_nxt;
    od_r   <= od_nxt;
    ook_r  <= ook_nxt;
    oovf_r <= oovf_nxt;
  end

  assign in_stall          = (state_r != gdad_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_end_year      = oy_r;
  assign out_end_month     = om_r;
  assign out_end_day       = od_r;
  assign out_date_valid    = ook_r;
  assign out_year_overflow = oovf_r;

  a_bad_date_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_date_valid) |->
      (out_end_year == '0 && out_end_month == gdad_pkg::MONTH_JAN &&
       out_end_day == gdad_pkg::DAY_FIRST && !out_year_overflow))
    else $error("illegal start date gave a non-default result");

  a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_year_overflow) |->
      (out_date_valid && out_end_year == gdad_pkg::YEAR_MAX &&
       out_end_month == gdad_pkg::MONTH_DEC && out_end_day == gdad_pkg::DAY_LAST))
    else $error("overflow result not saturated");

  a_roll_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdad_pkg::ST_ROLL) |->
      (y_r <= gdad_pkg::YEAR_MAX && m_r >= gdad_pkg::MONTH_JAN &&
       m_r <= gdad_pkg::MONTH_DEC))
    else $error("roll state left the legal date range");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == gdad_pkg::ST_DIV))
    else $error("accepted beat did not start the sequencer");

  a_month_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_month >= gdad_pkg::MONTH_JAN &&
                   out_end_month <= gdad_pkg::MONTH_DEC && out_end_day != '0))
    else $error("result month or day out of range");

endmodule
